>>> rtl/kcs_host_transaction_fsm_macros.svh
// ----------------------------------------------------------------------------
// KCS host transaction FSM assertion macros
// Shared property forms for the port-level checker.
// ----------------------------------------------------------------------------
`ifndef KCS_HOST_TRANSACTION_FSM_MACROS_SVH
`define KCS_HOST_TRANSACTION_FSM_MACROS_SVH

// same-cycle implication, checked while out of reset
`define KCS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked while out of reset
`define KCS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/kcs_pkg.sv
// ----------------------------------------------------------------------------
// KCS host package
// Types, codes and fixed constants of the KCS host transaction engine.
// ----------------------------------------------------------------------------
package kcs_pkg;

	localparam int BYTE_W    = 8;
	localparam int TIME_W    = 20;
	localparam int TMR_W     = 22;
	localparam int CNT_W     = 7;
	localparam int RETRY_W   = 4;
	localparam int CODE_W    = 4;
	localparam int WT_W      = 2;
	localparam int REG_IDX_W = 2;

	// register indexes on the configuration channel
	localparam logic [REG_IDX_W-1:0] REG_IBF_TIMEOUT = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_OBF_TIMEOUT = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_MAX_RETRIES = 2'd2;

	localparam logic [TIME_W-1:0]  TIMEOUT_RST     = 20'd1000000;
	localparam logic [RETRY_W-1:0] MAX_RETRIES_RST = 4'd10;

	localparam logic KIND_LOAD = 1'b0;
	localparam logic KIND_POLL = 1'b1;

	// status byte layout
	localparam int ST_OBF  = 0;
	localparam int ST_IBF  = 1;
	localparam int ST_ATTN = 2;

	localparam logic [1:0] IST_IDLE  = 2'd0;
	localparam logic [1:0] IST_READ  = 2'd1;
	localparam logic [1:0] IST_WRITE = 2'd2;
	localparam logic [1:0] IST_ERROR = 2'd3;

	localparam logic [BYTE_W-1:0] CMD_ABORT  = 8'h60;
	localparam logic [BYTE_W-1:0] CMD_WSTART = 8'h61;
	localparam logic [BYTE_W-1:0] CMD_WEND   = 8'h62;
	localparam logic [BYTE_W-1:0] CMD_READ   = 8'h68;

	typedef enum logic [3:0] {
		PH_IDLE   = 4'd0,
		PH_START  = 4'd1,
		PH_WSTART = 4'd2,
		PH_WRITE  = 4'd3,
		PH_WEND   = 4'd4,
		PH_READ   = 4'd5,
		PH_ERR0   = 4'd6,
		PH_ERR1   = 4'd7,
		PH_ERR2   = 4'd8,
		PH_ERR3   = 4'd9,
		PH_HOSED  = 4'd10
	} phase_t;

	typedef enum logic [CODE_W-1:0] {
		CODE_AGAIN    = 4'd0,
		CODE_DELAY    = 4'd1,
		CODE_IDLE     = 4'd2,
		CODE_ATTN     = 4'd3,
		CODE_COMPLETE = 4'd4,
		CODE_HOSED    = 4'd5,
		CODE_STARTED  = 4'd6,
		CODE_BAD_SIZE = 4'd7,
		CODE_BUSY     = 4'd8,
		CODE_TAKEN    = 4'd9
	} code_t;

	typedef enum logic [WT_W-1:0] {
		WT_NONE = 2'd0,
		WT_CMD  = 2'd1,
		WT_DATA = 2'd2
	} wtgt_t;

	// what one step decided, before the payload is formed
	typedef struct packed {
		code_t             code;
		logic              data_read;
		wtgt_t             write_target;
		logic [BYTE_W-1:0] write_value;
		logic              capture;
		logic              mem_re;
		logic              mem_we;
	} step_t;

	typedef struct packed {
		code_t             code;
		logic              data_read;
		wtgt_t             write_target;
		logic [BYTE_W-1:0] write_value;
		logic              resp_valid;
		logic [BYTE_W-1:0] resp_byte;
		logic              resp_truncated;
	} result_t;

endpackage

>>> rtl/kcs_item_if.sv
// ----------------------------------------------------------------------------
// KCS item channel
// Request bytes and poll events into the host engine.
// ----------------------------------------------------------------------------
interface kcs_item_if;
	logic                         valid;
	logic                         ready;
	logic                         kind;
	logic [kcs_pkg::BYTE_W-1:0]   request_byte;
	logic                         last_byte;
	logic [kcs_pkg::BYTE_W-1:0]   status_byte;
	logic [kcs_pkg::BYTE_W-1:0]   data_in;
	logic [kcs_pkg::TIME_W-1:0]   elapsed_us;

	modport source (output valid, kind, request_byte, last_byte, status_byte, data_in,
		elapsed_us, input ready);
	modport sink (input valid, kind, request_byte, last_byte, status_byte, data_in,
		elapsed_us, output ready);
endinterface

>>> rtl/kcs_result_if.sv
// ----------------------------------------------------------------------------
// KCS result channel
// One result per item: completion code, register accesses, response byte.
// ----------------------------------------------------------------------------
interface kcs_result_if;
	logic                         valid;
	logic                         ready;
	logic [kcs_pkg::CODE_W-1:0]   code;
	logic                         data_read;
	logic [kcs_pkg::WT_W-1:0]     write_target;
	logic [kcs_pkg::BYTE_W-1:0]   write_value;
	logic                         resp_valid;
	logic [kcs_pkg::BYTE_W-1:0]   resp_byte;
	logic                         resp_truncated;

	modport source (output valid, code, data_read, write_target, write_value, resp_valid,
		resp_byte, resp_truncated, input ready);
	modport sink (input valid, code, data_read, write_target, write_value, resp_valid,
		resp_byte, resp_truncated, output ready);
endinterface

>>> rtl/kcs_cfg_if.sv
// ----------------------------------------------------------------------------
// KCS configuration channel
// Register writes: index and data.
// ----------------------------------------------------------------------------
interface kcs_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [kcs_pkg::REG_IDX_W-1:0]  reg_index;
	logic [kcs_pkg::TIME_W-1:0]     wdata;

	modport source (output valid, reg_index, wdata, input ready);
	modport sink (input valid, reg_index, wdata, output ready);
endinterface

>>> rtl/kcs_host_transaction_fsm.sv
// ----------------------------------------------------------------------------
// KCS host transaction FSM
// Host side of a KCS interface: request buffer, write/read phases, timeouts
// and abort/retry recovery.
// ----------------------------------------------------------------------------
//  channel   dir   carries
//  item      in    load byte (kind 0) or poll event (kind 1)
//  result    out   code, register read/write, response byte, truncation
//  cfg       in    register writes (ibf/obf timeout, retry limit)
//
// one item per cycle; its result sits in the output register the cycle after
// the transfer. the request buffer is a synchronous ram read at transfer time
// (one read port), its data registered alongside the result.
// reset clears the control state; the request buffer has no clearing pass.
// item ready drops only while a result is held and the sink is not ready.
module kcs_host_transaction_fsm #(
	parameter int MAX_REQUEST  = 80,
	parameter int MAX_RESPONSE = 80
) (
	input  logic         clk,
	input  logic         arst_n,
	kcs_item_if.sink     item,
	kcs_result_if.source result,
	kcs_cfg_if.sink      cfg
);
	import kcs_pkg::*;

	localparam int AW = (MAX_REQUEST > 1) ? $clog2(MAX_REQUEST) : 1;
	localparam logic [CNT_W-1:0] MAX_REQ_C = CNT_W'(MAX_REQUEST);
	localparam logic [CNT_W-1:0] MAX_RSP_C = CNT_W'(MAX_RESPONSE);
	localparam logic signed [TMR_W-1:0] TMR_RST = $signed({2'b00, TIMEOUT_RST});

	// configuration
	logic [TIME_W-1:0]  ibf_to_q;
	logic [TIME_W-1:0]  obf_to_q;
	logic [RETRY_W-1:0] max_retries_q;

	// machine state
	phase_t                    phase_q, ph_d;
	logic [CNT_W-1:0]          load_cnt_q, load_d;
	logic [CNT_W-1:0]          send_pos_q, send_pos_d;
	logic [CNT_W-1:0]          send_left_q, send_left_d;
	logic [CNT_W-1:0]          req_len_q, req_len_d;
	logic [CNT_W-1:0]          resp_cnt_q, resp_d;
	logic                      trunc_q, trunc_d;
	logic [RETRY_W-1:0]        retry_q, retry_d;
	logic signed [TMR_W-1:0]   ibf_left_q, ibf_d;
	logic signed [TMR_W-1:0]   obf_left_q, obf_d;

	logic [BYTE_W-1:0] req_mem [MAX_REQUEST];
	logic [BYTE_W-1:0] rd_data_q;

	logic    valid_s1;
	logic    mem_sel_s1;
	result_t res_s1;

	step_t   step;
	result_t res_d;
	logic    item_acc;
	logic    cfg_acc;

	logic signed [TMR_W-1:0] dt_s;
	logic signed [TMR_W-1:0] ibf_rl;
	logic signed [TMR_W-1:0] obf_rl;
	logic signed [TMR_W-1:0] ibf_sub;
	logic [1:0]              ist;
	logic                    done;

	function automatic void recover(inout phase_t ph, inout logic [RETRY_W-1:0] retry,
		input logic [RETRY_W-1:0] limit);
		if (retry >= limit) begin
			ph = PH_HOSED;
		end else begin
			retry = retry + 1'b1;
			ph = PH_ERR0;
		end
	endfunction

	// obf wait: 1 when the wait is over, by obf or by timeout
	function automatic logic obf_wait(input logic obf, input logic signed [TMR_W-1:0] dt,
		input logic signed [TMR_W-1:0] reload, input logic [RETRY_W-1:0] limit,
		inout logic signed [TMR_W-1:0] left, inout phase_t ph,
		inout logic [RETRY_W-1:0] retry);
		logic signed [TMR_W-1:0] diff;
		logic                    ok;
		ok = 1'b1;
		diff = left - dt;
		if (!obf) begin
			if (diff[TMR_W-1]) begin
				left = '1;
				recover(ph, retry, limit);
			end else begin
				left = diff;
				ok = 1'b0;
			end
		end else begin
			left = reload;
		end
		return ok;
	endfunction

	assign item_acc   = item.valid && item.ready;
	assign cfg_acc    = cfg.valid && cfg.ready;
	assign item.ready = !valid_s1 || result.ready;
	assign cfg.ready  = 1'b1;

	assign dt_s   = $signed({2'b00, item.elapsed_us});
	assign ibf_rl = $signed({2'b00, ibf_to_q});
	assign obf_rl = $signed({2'b00, obf_to_q});
	assign ist    = item.status_byte[7:6];

	// next state and step decision
	always_comb begin
		ph_d        = phase_q;
		load_d      = load_cnt_q;
		send_pos_d  = send_pos_q;
		send_left_d = send_left_q;
		req_len_d   = req_len_q;
		resp_d      = resp_cnt_q;
		trunc_d     = trunc_q;
		retry_d     = retry_q;
		ibf_d       = ibf_left_q;
		obf_d       = obf_left_q;
		ibf_sub     = ibf_left_q - dt_s;
		done        = 1'b0;
		step        = '{code: CODE_AGAIN, data_read: 1'b0, write_target: WT_NONE,
			write_value: '0, capture: 1'b0, mem_re: 1'b0, mem_we: 1'b0};

		if (item.kind == KIND_LOAD) begin
			if (phase_q != PH_IDLE && phase_q != PH_HOSED) begin
				step.code = CODE_BUSY;
			end else if (load_cnt_q >= MAX_REQ_C) begin
				load_d    = '0;
				step.code = CODE_BAD_SIZE;
			end else begin
				step.mem_we = 1'b1;
				load_d      = load_cnt_q + 1'b1;
				if (!item.last_byte) begin
					step.code = CODE_TAKEN;
				end else if (load_d < CNT_W'(2)) begin
					load_d    = '0;
					step.code = CODE_BAD_SIZE;
				end else begin
					req_len_d   = load_d;
					send_left_d = load_d;
					send_pos_d  = '0;
					resp_d      = '0;
					retry_d     = '0;
					trunc_d     = 1'b0;
					load_d      = '0;
					ph_d        = PH_START;
					ibf_d       = ibf_rl;
					obf_d       = obf_rl;
					step.code   = CODE_STARTED;
				end
			end
		end else begin
			if (item.status_byte[ST_IBF]) begin
				if (ibf_sub[TMR_W-1]) begin
					recover(ph_d, retry_d, max_retries_q);
					ibf_d = ibf_rl;
				end else begin
					ibf_d     = ibf_sub;
					step.code = CODE_DELAY;
					done      = 1'b1;
				end
			end else begin
				ibf_d = ibf_rl;
			end

			if (!done) begin
				// dispatch on the phase left by an ibf recovery
				case (ph_d)
					PH_IDLE: begin
						step.data_read = item.status_byte[ST_OBF];
						step.code = item.status_byte[ST_ATTN] ? CODE_ATTN : CODE_IDLE;
						done = 1'b1;
					end
					PH_START: begin
						if (ist != IST_IDLE) begin
							recover(ph_d, retry_d, max_retries_q);
						end else begin
							step.data_read    = item.status_byte[ST_OBF];
							step.write_target = WT_CMD;
							step.write_value  = CMD_WSTART;
							ph_d              = PH_WSTART;
						end
					end
					PH_WSTART, PH_WRITE: begin
						if (ist != IST_WRITE) begin
							recover(ph_d, retry_d, max_retries_q);
						end else begin
							step.data_read = (ph_d == PH_WSTART) ? 1'b1 :
								item.status_byte[ST_OBF];
							if (send_left_d == CNT_W'(1)) begin
								step.write_target = WT_CMD;
								step.write_value  = CMD_WEND;
								ph_d              = PH_WEND;
							end else begin
								step.write_target = WT_DATA;
								step.mem_re       = (send_pos_d < MAX_REQ_C);
								send_pos_d        = send_pos_d + 1'b1;
								send_left_d       = send_left_d - 1'b1;
								ph_d              = PH_WRITE;
							end
						end
					end
					PH_WEND: begin
						if (ist != IST_WRITE) begin
							recover(ph_d, retry_d, max_retries_q);
						end else begin
							step.data_read    = item.status_byte[ST_OBF];
							step.write_target = WT_DATA;
							step.mem_re       = (send_pos_d < MAX_REQ_C);
							send_pos_d        = send_pos_d + 1'b1;
							send_left_d       = send_left_d - 1'b1;
							ph_d              = PH_READ;
						end
					end
					PH_READ: begin
						if (!(ist inside {IST_IDLE, IST_READ})) begin
							recover(ph_d, retry_d, max_retries_q);
						end else if (ist == IST_READ) begin
							if (!obf_wait(item.status_byte[ST_OBF], dt_s, obf_rl,
								max_retries_q, obf_d, ph_d, retry_d)) begin
								step.code = CODE_DELAY;
								done      = 1'b1;
							end else begin
								step.data_read = 1'b1;
								if (resp_d >= MAX_RSP_C) begin
									trunc_d = 1'b1;
								end else begin
									step.capture = 1'b1;
									resp_d       = resp_d + 1'b1;
								end
								step.write_target = WT_DATA;
								step.write_value  = CMD_READ;
							end
						end else begin
							step.data_read = item.status_byte[ST_OBF];
							req_len_d      = '0;
							ph_d           = PH_IDLE;
							step.code      = CODE_COMPLETE;
							done           = 1'b1;
						end
					end
					PH_ERR0: begin
						step.data_read    = item.status_byte[ST_OBF];
						step.write_target = WT_CMD;
						step.write_value  = CMD_ABORT;
						ph_d              = PH_ERR1;
					end
					PH_ERR1: begin
						step.data_read    = item.status_byte[ST_OBF];
						step.write_target = WT_DATA;
						ph_d              = PH_ERR2;
					end
					PH_ERR2: begin
						if (ist != IST_READ) begin
							recover(ph_d, retry_d, max_retries_q);
						end else if (!obf_wait(item.status_byte[ST_OBF], dt_s, obf_rl,
							max_retries_q, obf_d, ph_d, retry_d)) begin
							step.code = CODE_DELAY;
							done      = 1'b1;
						end else begin
							step.data_read    = item.status_byte[ST_OBF];
							step.write_target = WT_DATA;
							step.write_value  = CMD_READ;
							ph_d              = PH_ERR3;
						end
					end
					PH_ERR3: begin
						if (ist != IST_IDLE) begin
							recover(ph_d, retry_d, max_retries_q);
						end else if (!obf_wait(item.status_byte[ST_OBF], dt_s, obf_rl,
							max_retries_q, obf_d, ph_d, retry_d)) begin
							step.code = CODE_DELAY;
							done      = 1'b1;
						end else begin
							step.data_read = item.status_byte[ST_OBF];
							if (req_len_d != '0) begin
								// retry the whole request
								send_left_d       = req_len_d;
								send_pos_d        = '0;
								resp_d            = '0;
								ph_d              = PH_WSTART;
								ibf_d             = ibf_rl;
								obf_d             = obf_rl;
								step.write_target = WT_CMD;
								step.write_value  = CMD_WSTART;
							end else begin
								ph_d      = PH_IDLE;
								step.code = CODE_COMPLETE;
								done      = 1'b1;
							end
						end
					end
					default: begin
						// hosed by ibf timeout stays hosed until a new request
						ph_d      = PH_HOSED;
						step.code = CODE_HOSED;
						done      = 1'b1;
					end
				endcase

				if (!done) begin
					if (ph_d == PH_HOSED) begin
						ph_d        = PH_IDLE;
						send_pos_d  = '0;
						send_left_d = '0;
						req_len_d   = '0;
						resp_d      = '0;
						retry_d     = '0;
						trunc_d     = 1'b0;
						ibf_d       = ibf_rl;
						obf_d       = obf_rl;
						step.code   = CODE_HOSED;
					end else begin
						step.code = CODE_AGAIN;
					end
				end
			end
		end
	end

	// result payload
	always_comb begin
		res_d.code           = step.code;
		res_d.data_read      = step.data_read;
		res_d.write_target   = step.write_target;
		res_d.write_value    = step.write_value;
		res_d.resp_valid     = step.capture;
		res_d.resp_byte      = step.capture ? item.data_in : '0;
		res_d.resp_truncated = (item.kind == KIND_POLL) ? trunc_d : 1'b0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ibf_to_q      <= TIMEOUT_RST;
			obf_to_q      <= TIMEOUT_RST;
			max_retries_q <= MAX_RETRIES_RST;
			phase_q       <= PH_IDLE;
			load_cnt_q    <= '0;
			send_pos_q    <= '0;
			send_left_q   <= '0;
			req_len_q     <= '0;
			resp_cnt_q    <= '0;
			trunc_q       <= 1'b0;
			retry_q       <= '0;
			ibf_left_q    <= TMR_RST;
			obf_left_q    <= TMR_RST;
			valid_s1      <= 1'b0;
		end else begin
			if (cfg_acc) begin
				case (cfg.reg_index)
					REG_IBF_TIMEOUT: ibf_to_q      <= cfg.wdata;
					REG_OBF_TIMEOUT: obf_to_q      <= cfg.wdata;
					REG_MAX_RETRIES: max_retries_q <= cfg.wdata[RETRY_W-1:0];
					default: ;
				endcase
			end
			if (item_acc) begin
				phase_q     <= ph_d;
				load_cnt_q  <= load_d;
				send_pos_q  <= send_pos_d;
				send_left_q <= send_left_d;
				req_len_q   <= req_len_d;
				resp_cnt_q  <= resp_d;
				trunc_q     <= trunc_d;
				retry_q     <= retry_d;
				ibf_left_q  <= ibf_d;
				obf_left_q  <= obf_d;
			end
			if (item_acc) begin
				valid_s1 <= 1'b1;
			end else if (result.ready) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item_acc) begin
			res_s1     <= res_d;
			mem_sel_s1 <= step.mem_re;
		end
	end

	// request buffer: loads only while idle/hosed, reads only in write phases,
	// so a read never meets a write to the same entry in one cycle
	always_ff @(posedge clk) begin
		if (item_acc && step.mem_we) begin
			req_mem[load_cnt_q[AW-1:0]] <= item.request_byte;
		end
		if (item_acc && step.mem_re) begin
			rd_data_q <= req_mem[send_pos_q[AW-1:0]];
		end
	end

	assign result.valid          = valid_s1;
	assign result.code           = res_s1.code;
	assign result.data_read      = res_s1.data_read;
	assign result.write_target   = res_s1.write_target;
	assign result.write_value    = mem_sel_s1 ? rd_data_q : res_s1.write_value;
	assign result.resp_valid     = res_s1.resp_valid;
	assign result.resp_byte      = res_s1.resp_byte;
	assign result.resp_truncated = res_s1.resp_truncated;

endmodule

>>> rtl/kcs_chk.sv
// ----------------------------------------------------------------------------
// KCS host port checker
// Port-level properties of the KCS host transaction engine, bound to the top.
// ----------------------------------------------------------------------------
`include "kcs_host_transaction_fsm_macros.svh"

module kcs_chk (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       item_valid,
	input logic                       item_ready,
	input logic                       item_kind,
	input logic                       result_valid,
	input logic                       result_ready,
	input logic [kcs_pkg::CODE_W-1:0] code,
	input logic                       data_read,
	input logic [kcs_pkg::WT_W-1:0]   write_target,
	input logic [kcs_pkg::BYTE_W-1:0] write_value,
	input logic                       resp_valid,
	input logic [kcs_pkg::BYTE_W-1:0] resp_byte,
	input logic                       resp_truncated
);
	import kcs_pkg::*;

	logic        item_acc;
	logic        load_acc;
	logic        load_quiet;
	logic        read_cmd;
	logic        stall;
	logic [24:0] payload;

	assign item_acc   = item_valid && item_ready;
	assign load_acc   = item_acc && item_kind == KIND_LOAD;
	assign load_quiet = !data_read && write_target == WT_NONE && !resp_truncated;
	assign read_cmd   = data_read && write_target == WT_DATA && write_value == CMD_READ;
	assign stall      = result_valid && !result_ready;
	assign payload    = {code, data_read, write_target, write_value, resp_valid, resp_byte,
		resp_truncated};

	// every item transfer leaves a result in the output register
	`KCS_ASSERT_NEXT(a_item_gives_result, item_acc, result_valid, "no result after transfer")

	// a load touches no interface register and reports no truncation
	`KCS_ASSERT_NEXT(a_load_quiet, load_acc, load_quiet, "load item drove an access")

	// a captured response byte comes with a data read and a read command
	`KCS_ASSERT_NOW(a_capture_reads, result_valid && resp_valid, read_cmd, "byte without read")

	`KCS_ASSERT_NEXT(a_result_hold, stall, result_valid && $stable(payload), "stalled result changed")

endmodule

bind kcs_host_transaction_fsm kcs_chk u_kcs_chk (
	.clk            (clk),
	.arst_n         (arst_n),
	.item_valid     (item.valid),
	.item_ready     (item.ready),
	.item_kind      (item.kind),
	.result_valid   (result.valid),
	.result_ready   (result.ready),
	.code           (result.code),
	.data_read      (result.data_read),
	.write_target   (result.write_target),
	.write_value    (result.write_value),
	.resp_valid     (result.resp_valid),
	.resp_byte      (result.resp_byte),
	.resp_truncated (result.resp_truncated)
);
